### hdl/iaie_pkg.sv
package iaie_pkg;

   // Operation codes carried in the op field of a request word.
   typedef enum logic [3:0] {
      OP_READ   = 4'd0,
      OP_WRITE  = 4'd1,
      OP_INSERT = 4'd2,
      OP_ERASE  = 4'd3,
      OP_PUSH   = 4'd4,
      OP_POP    = 4'd5,
      OP_CLEAR  = 4'd6,
      OP_RESIZE = 4'd7,
      OP_ASSIGN = 4'd8,
      OP_FRONT  = 4'd9,
      OP_BACK   = 4'd10
   } op_type;

   // Status codes returned with every response word.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   // Request word.
   typedef struct packed {
      op_type             op;
      logic [6:0]         index;
      logic [6:0]         count;
      logic signed [31:0] value;
   } req_type;

   // Response word.
   typedef struct packed {
      logic signed [31:0] read_value;
      status_type         status;
      logic [6:0]         length;
      logic               is_empty;
   } rsp_type;

endpackage

### hdl/indexed_array_insert_erase_top.sv
// Channel   Direction  Handshake              Word
// request   in         start, busy            req_word  (op, index, count, value)
// response  out        rsp_strobe             rsp_word  (read_value, status, length, is_empty)
//
// A word is accepted at a rising edge with start high and busy low.
// Write, push, pop, clear, insert at the end, rejected requests and unknown codes answer
// in the next cycle and the block can take a new word right away. Read, front and back
// make one memory read. Insert moves the entries from the index up, erase those above it,
// and resize or assign write every entry they fill; all of these are set by the single
// write port of the entry memory, which moves one entry per cycle.
// Reset (synchronous) empties the array; the entry memory is not cleared. The
// response strobe lasts one cycle and cannot be stalled.
module indexed_array_insert_erase_top
   import iaie_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_strobe,
   output rsp_type rsp_word
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LW = $clog2(CAPACITY + 1);
   localparam int CW = (LW > 7) ? LW : 7;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_SHIFT_UP,
      S_PUT,
      S_SHIFT_DN,
      S_FILL
   } state_type;

   state_type          state_ff, state_in;
   logic [LW-1:0]      len_ff, len_in;
   logic [AW-1:0]      ptr_ff, ptr_in;
   logic [AW-1:0]      end_ff, end_in;
   logic signed [31:0] val_ff, val_in;
   logic               strobe_ff, strobe_in;
   rsp_type            rsp_ff, rsp_in;

   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic signed [31:0] mem_wdata;
   logic               mem_re;
   logic [AW-1:0]      mem_raddr;
   logic signed [31:0] mem_rdata;

   logic               resp_now;
   logic               resp_read;
   status_type         resp_status;

   logic [CW-1:0]      idx_x, cnt_x, n_x, cap_x, fill_start;

   assign idx_x = CW'(req_word.index);
   assign cnt_x = CW'(req_word.count);
   assign n_x   = CW'(len_ff);
   assign cap_x = CW'(CAPACITY);
   assign fill_start = (req_word.op == OP_RESIZE) ? n_x : '0;

   iaie_mem #(.DEPTH(CAPACITY)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // Sequencer: checks, memory accesses and the response word.
   always_comb begin
      state_in    = state_ff;
      len_in      = len_ff;
      ptr_in      = ptr_ff;
      end_in      = end_ff;
      val_in      = val_ff;
      mem_we      = 1'b0;
      mem_waddr   = '0;
      mem_wdata   = val_ff;
      mem_re      = 1'b0;
      mem_raddr   = '0;
      resp_now    = 1'b0;
      resp_read   = 1'b0;
      resp_status = ST_OK;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_word.op)
                  OP_READ: begin
                     if (idx_x >= n_x) begin
                        resp_now    = 1'b1;
                        resp_status = ST_RANGE;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = idx_x[AW-1:0];
                        state_in  = S_READ;
                     end
                  end
                  OP_WRITE: begin
                     resp_now = 1'b1;
                     if (idx_x >= n_x) begin
                        resp_status = ST_RANGE;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = idx_x[AW-1:0];
                        mem_wdata = req_word.value;
                     end
                  end
                  OP_INSERT: begin
                     if (idx_x > n_x) begin
                        resp_now    = 1'b1;
                        resp_status = ST_RANGE;
                     end else if (n_x >= cap_x) begin
                        resp_now    = 1'b1;
                        resp_status = ST_FULL;
                     end else begin
                        len_in = LW'(n_x + 1'b1);
                        if (idx_x == n_x) begin
                           // Append: no entries move.
                           resp_now  = 1'b1;
                           mem_we    = 1'b1;
                           mem_waddr = idx_x[AW-1:0];
                           mem_wdata = req_word.value;
                        end else begin
                           val_in    = req_word.value;
                           end_in    = idx_x[AW-1:0];
                           ptr_in    = AW'(n_x - 1'b1);
                           mem_re    = 1'b1;
                           mem_raddr = AW'(n_x - 1'b1);
                           state_in  = S_SHIFT_UP;
                        end
                     end
                  end
                  OP_ERASE: begin
                     if (idx_x >= n_x) begin
                        resp_now    = 1'b1;
                        resp_status = ST_RANGE;
                     end else begin
                        len_in = LW'(n_x - 1'b1);
                        if (CW'(idx_x + 1'b1) == n_x) begin
                           // Erasing the last entry moves nothing.
                           resp_now = 1'b1;
                        end else begin
                           ptr_in    = AW'(idx_x + 1'b1);
                           end_in    = AW'(n_x - 1'b1);
                           mem_re    = 1'b1;
                           mem_raddr = AW'(idx_x + 1'b1);
                           state_in  = S_SHIFT_DN;
                        end
                     end
                  end
                  OP_PUSH: begin
                     resp_now = 1'b1;
                     if (n_x >= cap_x) begin
                        resp_status = ST_FULL;
                     end else begin
                        len_in    = LW'(n_x + 1'b1);
                        mem_we    = 1'b1;
                        mem_waddr = n_x[AW-1:0];
                        mem_wdata = req_word.value;
                     end
                  end
                  OP_POP: begin
                     resp_now = 1'b1;
                     if (n_x == '0) begin
                        resp_status = ST_EMPTY;
                     end else begin
                        len_in = LW'(n_x - 1'b1);
                     end
                  end
                  OP_CLEAR: begin
                     resp_now = 1'b1;
                     len_in   = '0;
                  end
                  OP_RESIZE, OP_ASSIGN: begin
                     if (cnt_x > cap_x) begin
                        resp_now    = 1'b1;
                        resp_status = ST_FULL;
                     end else begin
                        len_in = LW'(cnt_x);
                        if (fill_start < cnt_x) begin
                           ptr_in   = fill_start[AW-1:0];
                           end_in   = AW'(cnt_x - 1'b1);
                           val_in   = req_word.value;
                           state_in = S_FILL;
                        end else begin
                           resp_now = 1'b1;
                        end
                     end
                  end
                  OP_FRONT: begin
                     if (n_x == '0) begin
                        resp_now    = 1'b1;
                        resp_status = ST_EMPTY;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                        state_in  = S_READ;
                     end
                  end
                  OP_BACK: begin
                     if (n_x == '0) begin
                        resp_now    = 1'b1;
                        resp_status = ST_EMPTY;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(n_x - 1'b1);
                        state_in  = S_READ;
                     end
                  end
                  default: begin
                     resp_now = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            resp_now  = 1'b1;
            resp_read = 1'b1;
            state_in  = S_IDLE;
         end
         S_SHIFT_UP: begin
            // Entry at ptr moves up one place while the next lower one is read.
            mem_we    = 1'b1;
            mem_waddr = AW'(ptr_ff + 1'b1);
            mem_wdata = mem_rdata;
            if (ptr_ff == end_ff) begin
               state_in = S_PUT;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = AW'(ptr_ff - 1'b1);
               ptr_in    = AW'(ptr_ff - 1'b1);
            end
         end
         S_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = end_ff;
            mem_wdata = val_ff;
            resp_now  = 1'b1;
            state_in  = S_IDLE;
         end
         S_SHIFT_DN: begin
            // Entry at ptr moves down one place while the next higher one is read.
            mem_we    = 1'b1;
            mem_waddr = AW'(ptr_ff - 1'b1);
            mem_wdata = mem_rdata;
            if (ptr_ff == end_ff) begin
               resp_now = 1'b1;
               state_in = S_IDLE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = AW'(ptr_ff + 1'b1);
               ptr_in    = AW'(ptr_ff + 1'b1);
            end
         end
         S_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = val_ff;
            if (ptr_ff == end_ff) begin
               resp_now = 1'b1;
               state_in = S_IDLE;
            end else begin
               ptr_in = AW'(ptr_ff + 1'b1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response word built from the length after the operation.
   always_comb begin
      strobe_in           = resp_now;
      rsp_in              = rsp_ff;
      if (resp_now) begin
         rsp_in.read_value = resp_read ? mem_rdata : 32'sd0;
         rsp_in.status     = resp_status;
         rsp_in.length     = 7'(len_in);
         rsp_in.is_empty   = (len_in == '0);
      end
   end

   // State, length and registered response.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         len_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         len_ff    <= len_in;
         strobe_ff <= strobe_in;
      end
      ptr_ff <= ptr_in;
      end_ff <= end_in;
      val_ff <= val_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

   // The length never passes the capacity.
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      CW'(len_ff) <= cap_x)
      else $error("length above capacity");

   // An idle cycle without a request is followed by no response.
   a_no_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !start) |=> !rsp_strobe)
      else $error("response without a request");

   // The empty flag agrees with the stored length while a response is shown.
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_word.is_empty == (len_ff == '0)))
      else $error("empty flag mismatch");

   // Writes stay inside the array.
   a_waddr: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (CW'(mem_waddr) < cap_x))
      else $error("write beyond capacity");

   // A shift never reads the entry it writes in the same cycle.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("read and write collide");

endmodule

### hdl/iaie_mem.sv
module iaie_mem
   import iaie_pkg::*;
#(
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [AW-1:0]     waddr,
   input  logic signed [31:0] wdata,
   input  logic              re,
   input  logic [AW-1:0]     raddr,
   output logic signed [31:0] rdata
);

   logic signed [31:0] entries_ff [DEPTH];
   logic signed [31:0] rdata_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (we) begin
         entries_ff[waddr] <= wdata;
      end
   end

   // Single read port with registered data.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= entries_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### tb/array_op_checker.sv
// Watches both channels of the array block, predicts each response word from
// its own copy of the array and compares the response words in order.
module array_op_checker
   import iaie_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_word,
   input  logic    rsp_strobe,
   input  rsp_type rsp_word,
   output int      mismatch_count,
   output int      due_count
);

   // Shadow copy of the array contents and its length.
   logic signed [31:0] shadow_words [CAPACITY];
   int                 shadow_len = 0;

   // Response words predicted but not yet seen, oldest first.
   rsp_type            due_responses [$];

   // Applies one request word to the shadow array and returns the response word.
   // Every check is made before any change, so a rejected request changes nothing.
   function automatic rsp_type predict_array_op(req_type rq);
      rsp_type r;
      int      n;
      int      idx;
      int      cnt;
      int      i;
      r = '0;
      r.status = ST_OK;
      n = shadow_len;
      idx = int'(rq.index);
      cnt = int'(rq.count);
      case (rq.op)
         OP_READ: begin
            if (idx >= n) r.status = ST_RANGE;
            else r.read_value = shadow_words[idx];
         end
         OP_WRITE: begin
            if (idx >= n) r.status = ST_RANGE;
            else shadow_words[idx] = rq.value;
         end
         OP_INSERT: begin
            // The index check wins over the capacity check.
            if (idx > n) r.status = ST_RANGE;
            else if (n >= CAPACITY) r.status = ST_FULL;
            else begin
               for (i = n; i > idx; i--) shadow_words[i] = shadow_words[i - 1];
               shadow_words[idx] = rq.value;
               shadow_len = n + 1;
            end
         end
         OP_ERASE: begin
            if (idx >= n) r.status = ST_RANGE;
            else begin
               for (i = idx; i + 1 < n; i++) shadow_words[i] = shadow_words[i + 1];
               shadow_len = n - 1;
            end
         end
         OP_PUSH: begin
            if (n >= CAPACITY) r.status = ST_FULL;
            else begin
               shadow_words[n] = rq.value;
               shadow_len = n + 1;
            end
         end
         OP_POP: begin
            if (n == 0) r.status = ST_EMPTY;
            else shadow_len = n - 1;
         end
         OP_CLEAR: begin
            shadow_len = 0;
         end
         OP_RESIZE: begin
            // Only the entries past the old length take the fill value.
            if (cnt > CAPACITY) r.status = ST_FULL;
            else begin
               for (i = n; i < cnt; i++) shadow_words[i] = rq.value;
               shadow_len = cnt;
            end
         end
         OP_ASSIGN: begin
            if (cnt > CAPACITY) r.status = ST_FULL;
            else begin
               for (i = 0; i < cnt; i++) shadow_words[i] = rq.value;
               shadow_len = cnt;
            end
         end
         OP_FRONT: begin
            if (n == 0) r.status = ST_EMPTY;
            else r.read_value = shadow_words[0];
         end
         OP_BACK: begin
            if (n == 0) r.status = ST_EMPTY;
            else r.read_value = shadow_words[n - 1];
         end
         default: begin
            // Spare codes leave everything as it is.
         end
      endcase
      r.length = shadow_len[6:0];
      r.is_empty = (shadow_len == 0);
      return r;
   endfunction

   // Compares one field of a response word and reports a difference.
   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   // A response word always belongs to an earlier request word, so it is checked
   // before a request word accepted at the same edge is predicted.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         due_responses.delete();
         shadow_len = 0;
      end else begin
         if ($isunknown({busy, rsp_strobe})) begin
            mismatch_count++;
            $display("%0t: handshake mismatch: expected known busy and strobe, actual %b %b",
                     $time, busy, rsp_strobe);
         end
         if (rsp_strobe === 1'b1) begin
            if (due_responses.size() == 0) begin
               mismatch_count++;
               $display("%0t: response mismatch: expected no word, actual %p",
                        $time, rsp_word);
            end else begin
               want = due_responses.pop_front();
               check_field("read_value", want.read_value, rsp_word.read_value);
               check_field("status", want.status, rsp_word.status);
               check_field("length", want.length, rsp_word.length);
               check_field("is_empty", want.is_empty, rsp_word.is_empty);
            end
         end
         if (start && busy === 1'b0)
            due_responses.insert(due_responses.size(), predict_array_op(req_word));
      end
      due_count = due_responses.size();
   end

endmodule

### tb/tb.sv
module tb;
   import iaie_pkg::*;

   localparam int          CAPACITY       = 64;
   localparam int          RESET_CYCLES   = 9;
   localparam int          RANDOM_ITEMS   = 800;
   localparam int          DRAIN_CYCLES   = 100;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam logic [3:0]  OP_SPARE_FIRST = 4'd11;
   localparam logic [3:0]  OP_SPARE_LAST  = 4'd15;
   localparam logic [31:0] WORD_MIN       = 32'h8000_0000;
   localparam logic [31:0] WORD_MAX       = 32'h7fff_ffff;
   localparam logic [31:0] WORD_ONES      = 32'hffff_ffff;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_word = '0;
   logic    rsp_strobe;
   rsp_type rsp_word;

   int         mismatch_count;
   int         due_count;
   int         quiet_cycles = 0;
   logic [6:0] seen_length = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   indexed_array_insert_erase_top #(
      .CAPACITY (CAPACITY)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   array_op_checker #(
      .CAPACITY (CAPACITY)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_word       (req_word),
      .rsp_strobe     (rsp_strobe),
      .rsp_word       (rsp_word),
      .mismatch_count (mismatch_count),
      .due_count      (due_count)
   );

   // Track the reported length so that random indexes land near the live range.
   always @(posedge clock) begin
      if (rsp_strobe === 1'b1) seen_length <= rsp_word.length;
   end

   // End the run when neither channel moves a word for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("** indexed_array_insert_erase_top: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type make_word(op_type op, int index, int count, logic [31:0] value);
      req_type w;
      w.op = op;
      w.index = index[6:0];
      w.count = count[6:0];
      w.value = value;
      return w;
   endfunction

   // Builds one random request word. While growing, pushes and inserts dominate;
   // while shrinking, erases and pops do. Indexes and counts cluster around the
   // current length, with some values far out of range.
   function automatic req_type random_word(int len, bit grow);
      req_type w;
      int      pick;
      int      roll;
      w.value = $urandom;
      roll = $urandom_range(0, 11);
      if (roll == 0) w.value = WORD_MIN;
      else if (roll == 1) w.value = WORD_MAX;
      else if (roll == 2) w.value = '0;
      else if (roll == 3) w.value = WORD_ONES;

      pick = $urandom_range(0, 99);
      if (pick < 3) w.op = op_type'(4'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)));
      else if (pick < 15) w.op = OP_READ;
      else if (pick < 25) w.op = OP_WRITE;
      else if (pick < 31) w.op = OP_FRONT;
      else if (pick < 37) w.op = OP_BACK;
      else if (pick < 41) w.op = OP_RESIZE;
      else if (pick < 43) w.op = OP_ASSIGN;
      else if (grow) begin
         if (pick < 68) w.op = OP_PUSH;
         else if (pick < 88) w.op = OP_INSERT;
         else if (pick < 94) w.op = OP_ERASE;
         else if (pick < 99) w.op = OP_POP;
         else w.op = OP_CLEAR;
      end else begin
         if (pick < 50) w.op = OP_PUSH;
         else if (pick < 58) w.op = OP_INSERT;
         else if (pick < 78) w.op = OP_ERASE;
         else if (pick < 97) w.op = OP_POP;
         else w.op = OP_CLEAR;
      end

      roll = $urandom_range(0, 9);
      if (roll < 6) w.index = 7'($urandom_range(0, len));
      else if (roll == 6) w.index = 7'(len);
      else if (roll == 7) w.index = 7'((len > 0) ? len - 1 : 0);
      else if (roll == 8) w.index = 7'($urandom_range(0, 127));
      else w.index = '0;

      roll = $urandom_range(0, 9);
      if (roll < 4) w.count = 7'(grow ? $urandom_range(len, CAPACITY) : $urandom_range(0, len));
      else if (roll < 7) w.count = 7'($urandom_range(0, 8));
      else if (roll == 7) w.count = 7'(CAPACITY);
      else if (roll == 8) w.count = 7'($urandom_range(CAPACITY + 1, 127));
      else w.count = 7'($urandom_range(0, CAPACITY));
      return w;
   endfunction

   // Presents one request word and returns at the edge that accepts it. The start
   // line stays high so that the next word of a burst follows without a gap.
   task automatic send_word(req_type w);
      req_word <= w;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   initial begin
      int  k;
      bit  grow;
      bit  idle_on;
      int  burst_left;

      grow = 1'b1;
      idle_on = 1'b1;
      burst_left = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words: empty-array errors, range and capacity limits, extremes.
      send_word(make_word(OP_POP, 0, 0, '0));
      send_word(make_word(OP_FRONT, 0, 0, '0));
      send_word(make_word(OP_BACK, 0, 0, '0));
      send_word(make_word(OP_READ, 127, 0, '0));
      send_word(make_word(OP_ERASE, 0, 0, '0));
      send_word(make_word(OP_INSERT, 1, 0, WORD_ONES));
      send_word(make_word(OP_WRITE, 0, 0, WORD_ONES));
      send_word(make_word(OP_INSERT, 0, 0, WORD_MAX));
      send_word(make_word(OP_PUSH, 0, 0, WORD_MIN));
      send_word(make_word(OP_INSERT, 1, 0, '0));
      send_word(make_word(OP_WRITE, 2, 0, WORD_ONES));
      send_word(make_word(OP_READ, 1, 0, '0));
      send_word(make_word(OP_FRONT, 0, 0, '0));
      send_word(make_word(OP_BACK, 0, 0, '0));
      send_word(make_word(OP_ERASE, 0, 0, '0));
      send_word(make_word(OP_RESIZE, 0, CAPACITY + 1, WORD_ONES));
      send_word(make_word(OP_ASSIGN, 0, 127, WORD_ONES));
      send_word(make_word(OP_ASSIGN, 0, CAPACITY, WORD_MIN));
      send_word(make_word(OP_PUSH, 0, 0, WORD_ONES));
      send_word(make_word(OP_INSERT, CAPACITY, 0, WORD_ONES));
      send_word(make_word(OP_INSERT, CAPACITY + 1, 0, WORD_ONES));
      send_word(make_word(OP_ERASE, CAPACITY - 1, 0, '0));
      send_word(make_word(OP_RESIZE, 0, CAPACITY, WORD_MAX));
      send_word(make_word(OP_READ, CAPACITY - 1, 0, '0));
      send_word(make_word(op_type'(OP_SPARE_LAST), 127, 127, WORD_ONES));
      send_word(make_word(OP_CLEAR, 0, 0, '0));
      send_word(make_word(OP_RESIZE, 0, 3, 32'h5a5a_a5a5));

      // Random words, sent in bursts with random gaps; some stretches run without gaps.
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
         if (seen_length >= CAPACITY - 2) grow = 1'b0;
         else if (seen_length <= 2) grow = 1'b1;
         else if ($urandom_range(0, 79) == 0) grow = !grow;
         if (idle_on && burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            burst_left = $urandom_range(1, 16);
         end
         if (burst_left > 0) burst_left--;
         send_word(random_word(int'(seen_length), grow));
      end
      start <= 1'b0;

      // Let every response word arrive, then give the block time to settle.
      while (due_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && due_count == 0)
         $display("** indexed_array_insert_erase_top: PASSED **");
      else
         $display("** indexed_array_insert_erase_top: FAILED **");
      $finish;
   end

endmodule

### files.f
hdl/iaie_pkg.sv
hdl/iaie_mem.sv
hdl/indexed_array_insert_erase_top.sv
tb/array_op_checker.sv
tb/tb.sv
